FILE: design/glq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glq_pkg
// Shared widths, commands and sequencer states for the grouped linked queue.
// ----------------------------------------------------------------------------
package glq_pkg;
  localparam int SlotCount  = 1024;
  localparam int GroupCount = 1024;
  localparam int ValueWidth = 20;
  localparam int SlotW      = $clog2(SlotCount);
  localparam int GroupW     = $clog2(GroupCount);
  localparam int CountW     = $clog2(SlotCount + 1);
  localparam int GroupInW   = 10;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  typedef enum logic {
    ST_OK   = 1'b0,
    ST_FULL = 1'b1
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EXEC
  } state_e;
endpackage

FILE: design/glq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glq_in_if / glq_out_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface glq_in_if;
  import glq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [ValueWidth-1:0] item_value;
  logic [GroupInW-1:0]   group_id;
  modport source (output valid, command, item_value, group_id, input ready);
  modport sink   (input valid, command, item_value, group_id, output ready);
endinterface

interface glq_out_if;
  import glq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  status;
  logic [ValueWidth-1:0] out_value;
  modport source (output valid, status, out_value, input ready);
  modport sink   (input valid, status, out_value, output ready);
endinterface

FILE: design/grouped_linked_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_linked_queue
// Team queue: entries join behind the last waiting member of their group.
// ----------------------------------------------------------------------------
// channel  dir  payload
// in_ch    in   command, item_value, group_id
// out_ch   out  status, out_value
//
// Each item is handled in order: the accept cycle reads the group's last slot,
// waiting bit, head entry and free-list link; S_READ then reads the link behind
// the group's last slot and the last slot of the head's group; S_EXEC
// writes back. A result waits in an output register; the next item is taken
// while it is held and stalls in write-back only if it produces a result
// before that one leaves. Reset clears control state at once; the group
// waiting memory is then cleared entry by entry with the input held off.
// ----------------------------------------------------------------------------
module grouped_linked_queue import glq_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  glq_in_if.sink   in_ch,
  glq_out_if.source out_ch
);
  logic [ValueWidth-1:0] val_mem [SlotCount];
  logic [SlotW-1:0]      link_mem [SlotCount];
  logic [GroupW-1:0]     grp_mem [SlotCount];
  logic [SlotW-1:0]      last_mem [GroupCount];
  logic                  wait_mem [GroupCount];

  state_e state_q, state_d;
  logic [SlotW-1:0]  head_q, tail_q, free_top_q;
  logic [CountW-1:0] occ_q, unused_q, free_size_q;
  logic [GroupW-1:0] clr_q;
  logic              cmd_q;
  logic [ValueWidth-1:0] val_q;
  logic [GroupW-1:0] grp_q;

  logic              ovalid_q;
  logic              ostat_q;
  logic [ValueWidth-1:0] oval_q;

  // registered memory reads
  logic [SlotW-1:0]  rd_last_q, rd_plink_q, rd_flink_q, rd_hlink_q, rd_hlast_q;
  logic [ValueWidth-1:0] rd_hval_q;
  logic [GroupW-1:0] rd_hgrp_q;
  logic              rd_wait_q, rd_hwait_q;

  logic accept, exec, exec_go, res_out;
  logic full, empty, use_free, last_hd;
  logic [GroupW-1:0] grp_in;
  logic [SlotW-1:0] new_slot;

  assign grp_in = in_ch.group_id[GroupW-1:0];
  assign in_ch.ready = (state_q == S_IDLE);
  assign accept = in_ch.valid && in_ch.ready;
  assign exec = (state_q == S_EXEC);

  assign full     = (occ_q == CountW'(SlotCount));
  assign empty    = (occ_q == '0);
  assign use_free = (free_size_q != '0);
  assign new_slot = use_free ? free_top_q : unused_q[SlotW-1:0];
  assign last_hd  = rd_hwait_q && (rd_hlast_q == head_q);
  assign res_out  = (cmd_q == CMD_ENQ) ? full : !empty;
  assign exec_go  = exec && !(res_out && ovalid_q && !out_ch.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == GroupW'(GroupCount - 1)) state_d = S_IDLE;
      S_IDLE:  if (accept) state_d = S_READ;
      S_READ:  state_d = S_EXEC;
      S_EXEC:  if (exec_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // read stages: group entry and head entry, then the entries they point at
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_last_q  <= last_mem[grp_in];
      rd_wait_q  <= wait_mem[grp_in];
      rd_flink_q <= link_mem[free_top_q];
      rd_hlink_q <= link_mem[head_q];
      rd_hval_q  <= val_mem[head_q];
      rd_hgrp_q  <= grp_mem[head_q];
    end
    if (state_q == S_READ) begin
      rd_plink_q <= link_mem[rd_last_q];
      rd_hlast_q <= last_mem[rd_hgrp_q];
      rd_hwait_q <= wait_mem[rd_hgrp_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      wait_mem[clr_q] <= 1'b0;
    end else if (exec_go) begin
      if (cmd_q == CMD_ENQ && !full) begin
        val_mem[new_slot]  <= val_q;
        grp_mem[new_slot]  <= grp_q;
        last_mem[grp_q]    <= new_slot;
        wait_mem[grp_q]    <= 1'b1;
        if (empty || !rd_wait_q) begin
          link_mem[new_slot] <= '0;
          if (!empty) link_mem[tail_q] <= new_slot;
        end else begin
          link_mem[new_slot]  <= rd_plink_q;
          link_mem[rd_last_q] <= new_slot;
        end
      end else if (cmd_q == CMD_DEQ && !empty) begin
        link_mem[head_q] <= free_top_q;
        if (last_hd) wait_mem[rd_hgrp_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      head_q <= '0; tail_q <= '0; free_top_q <= '0;
      occ_q <= '0; unused_q <= '0; free_size_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      ovalid_q <= (exec_go && res_out) || (ovalid_q && !out_ch.ready);
      if (exec_go) begin
        if (cmd_q == CMD_ENQ) begin
          if (!full) begin
            if (use_free) begin
              free_top_q  <= rd_flink_q;
              free_size_q <= free_size_q - 1'b1;
            end else begin
              unused_q <= unused_q + 1'b1;
            end
            if (empty) begin
              head_q <= new_slot; tail_q <= new_slot;
            end else if (!rd_wait_q || tail_q == rd_last_q) begin
              tail_q <= new_slot;
            end
            occ_q <= occ_q + 1'b1;
          end
        end else if (!empty) begin
          head_q      <= rd_hlink_q;
          occ_q       <= occ_q - 1'b1;
          free_top_q  <= head_q;
          free_size_q <= free_size_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_ch.command;
      val_q <= in_ch.item_value;
      grp_q <= grp_in;
    end
    if (exec_go && res_out) begin
      ostat_q <= (cmd_q == CMD_ENQ) ? ST_FULL : ST_OK;
      oval_q  <= (cmd_q == CMD_ENQ) ? '0 : rd_hval_q;
    end
  end

  assign out_ch.valid     = ovalid_q;
  assign out_ch.status    = ostat_q;
  assign out_ch.out_value = oval_q;

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CountW'(SlotCount)) else $error("occupancy overflow");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |-> !in_ch.ready) else $error("accept during execute");
  a_slot_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unused_q == occ_q + free_size_q) else $error("slot accounting broken");
endmodule
